[rtl/core/pcd_pkg.sv]
`timescale 1ns / 1ps

package pcd_pkg;

  // width of one assembled PCM sample
  localparam int SampleW  = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t RegSampleBytes  = 2'd0;
  localparam cfg_idx_t RegChannelCount = 2'd1;
  localparam cfg_idx_t RegMixMode      = 2'd2;

  localparam logic [2:0] ResetSampleBytes  = 3'd2;
  localparam logic [3:0] ResetChannelCount = 4'd2;
  localparam logic       ResetMixMode      = 1'b0;

  localparam logic MixAverage = 1'b0;
  localparam logic MixLeft    = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

endpackage

[rtl/core/pcd_div.sv]
`timescale 1ns / 1ps

module pcd_div #(
  parameter int SUM_W = 35,
  parameter int DIV_W = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [SUM_W-1:0]         dividend_i,
  input  logic        [DIV_W-1:0]         divisor_i,
  output logic                            done_o,
  output logic        [pcd_pkg::SampleW-1:0] quotient_o
);
  import pcd_pkg::*;

  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] mag_q, mag_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DIV_W:0]   trial;
  logic             fits;

  // restoring division on the magnitude, one quotient bit per cycle
  assign trial = {rem_q, mag_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W - 1);
      neg_d  = dividend_i[SUM_W-1];
      mag_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DIV_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = DIV_W'(trial);
      end
      mag_d = {mag_q[SUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? SampleW'(-mag_q[SampleW-1:0]) : mag_q[SampleW-1:0];

endmodule

[rtl/core/pcm_channel_downmix.sv]
`timescale 1ns / 1ps
// byte that does not end a frame: accepted in the cycle it is offered, input stays ready
// frame end in left mode: first output byte valid in the cycle after the transaction
// frame end in average mode: single restoring shift-subtract divider, one bit per cycle;
//   first output byte valid once the divider raises done and the state moves from S_DIV to S_EMIT
// then one output byte per cycle while not stalled; no input taken until the last
// reset (async, active low): 2 bytes, 2 channels, average mode, frame cleared

module pcm_channel_downmix #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  pcd_pkg::cfg_idx_t          cfg_index_i,
  input  pcd_pkg::cfg_data_t         cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       first_of_stream_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_sample_o
);
  import pcd_pkg::*;

  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CP_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W = SampleW + $clog2(MAX_CHANNELS);

  state_e state_q, state_d;

  logic [2:0]             sample_bytes_q, sample_bytes_d;
  logic [3:0]             channel_count_q, channel_count_d;
  logic                   mix_mode_q, mix_mode_d;
  logic [1:0]             bp_q, bp_d;
  logic [CP_W-1:0]        cp_q, cp_d;
  logic [SampleW-1:0]     asm_q, asm_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SampleW-1:0]     mono_q, mono_d;
  logic [1:0]             out_idx_q, out_idx_d;

  logic [2:0]              nbytes;
  logic [CH_W-1:0]         nch;
  logic                    cfg_acc, in_acc, out_acc;
  logic [1:0]              bp_cur;
  logic [CP_W-1:0]         cp_cur;
  logic [SampleW-1:0]      asm_cur, asm_new, s32;
  logic signed [SUM_W-1:0] sum_cur, s_ext, sum_new;
  logic                    sample_done, frame_done;
  logic                    div_start, div_done;
  logic [SampleW-1:0]      div_quot;

  // effective sample size and channel count
  always_comb begin
    if (sample_bytes_q == 3'd0) begin
      nbytes = 3'd1;
    end else if (sample_bytes_q > 3'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = sample_bytes_q;
    end
    if (channel_count_q == 4'd0) begin
      nch = CH_W'(1);
    end else if (int'(channel_count_q) > MAX_CHANNELS) begin
      nch = CH_W'(MAX_CHANNELS);
    end else begin
      nch = CH_W'(channel_count_q);
    end
  end

  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // frame assembly for the incoming byte
  always_comb begin
    bp_cur  = first_of_stream_i ? 2'd0 : bp_q;
    cp_cur  = first_of_stream_i ? '0 : cp_q;
    asm_cur = first_of_stream_i ? '0 : asm_q;
    sum_cur = first_of_stream_i ? '0 : sum_q;
    if ({1'b0, bp_cur} >= nbytes) begin
      bp_cur = 2'd0;
    end
    if (CH_W'(cp_cur) >= nch) begin
      cp_cur = '0;
    end
    asm_new = asm_cur | (SampleW'(data_byte_i) << {bp_cur, 3'b000});
    case (nbytes)
      3'd1:    s32 = {24'd0, asm_new[7:0]};
      3'd2:    s32 = {{16{asm_new[15]}}, asm_new[15:0]};
      3'd3:    s32 = {{8{asm_new[23]}}, asm_new[23:0]};
      default: s32 = asm_new;
    endcase
    s_ext = SUM_W'($signed(s32));
    if (mix_mode_q == MixLeft) begin
      sum_new = (cp_cur == '0) ? s_ext : sum_cur;
    end else begin
      sum_new = sum_cur + s_ext;
    end
    sample_done = ({1'b0, bp_cur} + 3'd1) == nbytes;
    frame_done  = sample_done && ((CH_W'(cp_cur) + CH_W'(1)) == nch);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && frame_done) begin
          state_d = (mix_mode_q == MixLeft) ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_acc && last_of_sample_o) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    sample_bytes_d  = sample_bytes_q;
    channel_count_d = channel_count_q;
    mix_mode_d      = mix_mode_q;
    bp_d            = bp_q;
    cp_d            = cp_q;
    asm_d           = asm_q;
    sum_d           = sum_q;
    mono_d          = mono_q;
    out_idx_d       = out_idx_q;
    div_start       = 1'b0;
    out_valid_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        out_idx_d = 2'd0;
        if (cfg_acc) begin
          unique case (cfg_index_i)
            RegSampleBytes:  sample_bytes_d  = cfg_data_i[2:0];
            RegChannelCount: channel_count_d = cfg_data_i;
            RegMixMode:      mix_mode_d      = cfg_data_i[0];
            default: ;
          endcase
          if (cfg_index_i == RegSampleBytes || cfg_index_i == RegChannelCount ||
              cfg_index_i == RegMixMode) begin
            bp_d  = 2'd0;
            cp_d  = '0;
            asm_d = '0;
            sum_d = '0;
          end
        end else if (in_acc) begin
          if (!sample_done) begin
            bp_d  = bp_cur + 2'd1;
            cp_d  = cp_cur;
            asm_d = asm_new;
            sum_d = sum_cur;
          end else begin
            bp_d  = 2'd0;
            asm_d = '0;
            if (!frame_done) begin
              cp_d  = cp_cur + CP_W'(1);
              sum_d = sum_new;
            end else begin
              cp_d      = '0;
              sum_d     = '0;
              mono_d    = sum_new[SampleW-1:0];
              div_start = mix_mode_q == MixAverage;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mono_d = div_quot;
        end
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          mono_d    = mono_q >> 8;
          out_idx_d = out_idx_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_byte_o       = mono_q[7:0];
  assign last_of_sample_o = ({1'b0, out_idx_q} + 3'd1) == nbytes;

  pcd_div #(
    .SUM_W(SUM_W),
    .DIV_W(CH_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (nch),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      sample_bytes_q  <= ResetSampleBytes;
      channel_count_q <= ResetChannelCount;
      mix_mode_q      <= ResetMixMode;
      bp_q            <= 2'd0;
      cp_q            <= '0;
      asm_q           <= '0;
      sum_q           <= '0;
      out_idx_q       <= 2'd0;
    end else begin
      state_q         <= state_d;
      sample_bytes_q  <= sample_bytes_d;
      channel_count_q <= channel_count_d;
      mix_mode_q      <= mix_mode_d;
      bp_q            <= bp_d;
      cp_q            <= cp_d;
      asm_q           <= asm_d;
      sum_q           <= sum_d;
      out_idx_q       <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mono_q <= mono_d;
  end

  // one frame in flight: input is never taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("input accepted while result pending");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider done outside divide state");

  // the last byte of a sample ends the output burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_of_sample_o) |=> !out_valid_o)
    else $error("output continued after last byte");

  // a left-mode frame never goes through the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (mix_mode_q == MixAverage))
    else $error("divider started in left mode");

endmodule
